@@ design/bqc_pkg.sv @@
// ============================================================================
// bqc_pkg - shared types and constants of the biquad cascade core
// Fixed-point formats, coefficient bundle, delay-word pair and register map.
// ============================================================================
package bqc_pkg;

    // fixed-point formats
    localparam int CW     = 20;               // coefficient, Q4.16
    localparam int DW     = 40;               // delay word / section signal, Q24.16
    localparam int OW     = 24;               // sample width
    localparam int FRAC   = 16;               // fraction bits
    localparam int PW     = CW + DW - FRAC;   // rounded product width
    localparam int CHAN_W = 3;

    // register map
    localparam int REG_SECTIONS = 4;          // sections with programmable coefficients
    localparam int NW           = 3 * CW;     // numerator register width
    localparam int FW           = 2 * CW;     // feedback register width
    localparam int APB_DW       = 64;
    localparam int APB_AW       = 6;          // eight registers at 8-byte spacing
    localparam int REG_IDX_LSB  = 3;

    localparam logic       REG_KIND_NUMER = 1'b0;
    localparam logic       REG_KIND_FBACK = 1'b1;
    localparam logic [NW-1:0] NUMER_RESET = NW'(65536);
    localparam logic [FW-1:0] FBACK_RESET = '0;

    // coefficients of one section
    typedef struct packed {
        logic signed [CW-1:0] b0;
        logic signed [CW-1:0] b1;
        logic signed [CW-1:0] b2;
        logic signed [CW-1:0] a1;
        logic signed [CW-1:0] a2;
    } t_coef_set;

    // one delay-memory entry: both delay words of a channel/section
    typedef struct packed {
        logic signed [DW-1:0] w2;
        logic signed [DW-1:0] w1;
    } t_delay_pair;

endpackage

@@ design/multichannel_biquad_cascade_core.sv @@
// ============================================================================
// multichannel_biquad_cascade_core - multichannel cascaded DF-II biquad filter
// Each item carries a channel number and a 24-bit sample and is filtered
// through SECTIONS biquad sections using that channel's delay words.
// One item is in work at a time. Its result goes to an output register, so
// the next item is taken while it waits there; a later result waits in turn
// until the register is free. The pace is set by the section recurrence:
// each section runs the w sum, the two-stage b0*w multiply and the y sum,
// while the delay-memory read and feedback products of the next section run
// underneath. After reset a clearing pass over all CHANNELS*SECTIONS entries
// (32 by default) zeroes the delay memory; no item is accepted during it,
// configuration writes are. A channel number at or above CHANNELS returns
// sample 0 and leaves all state alone.
// ============================================================================
module multichannel_biquad_cascade_core #(
    parameter int CHANNELS = 8,
    parameter int SECTIONS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [bqc_pkg::OW-1:0]          i_s_axis_tdata,  // [23:0] sample_in
    input  logic [bqc_pkg::CHAN_W-1:0]      i_s_axis_tuser,  // [2:0] chan
    // result items
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [bqc_pkg::OW-1:0]          o_m_axis_tdata,  // [23:0] sample_out
    output logic [bqc_pkg::CHAN_W-1:0]      o_m_axis_tuser,  // [2:0] chan_out
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bqc_pkg::APB_AW-1:0]      paddr,
    input  logic [bqc_pkg::APB_DW-1:0]      pwdata,
    output logic [bqc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import bqc_pkg::*;

    localparam int DEPTH = CHANNELS * SECTIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int SUMW  = PW + 2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_P0,     // read section 0
        S_P1,     // section 0 products, stage 1
        S_P2,     // section 0 products, stage 2
        S_WS,     // w sum
        S_B1,     // b0*w stage 1, write back, read next section
        S_B2,     // b0*w stage 2
        S_YS,     // y sum
        S_DONE
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr;
    logic [AW-1:0]        r_base;
    logic [SW-1:0]        r_sec;
    logic [CHAN_W-1:0]    r_chan;
    logic                 r_oor;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_w;
    t_coef_set            r_coef;
    logic                 r_ovalid;
    logic [OW-1:0]        r_odata;
    logic [CHAN_W-1:0]    r_ochan;

    t_coef_set            coefs [SECTIONS];
    t_delay_pair          rd_data;
    t_delay_pair          wr_data;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [SW-1:0]        rd_sec;
    logic                 last_sec;

    logic signed [PW-1:0]   p_a1w1;
    logic signed [PW-1:0]   p_a2w2;
    logic signed [PW-1:0]   p_b1w1;
    logic signed [PW-1:0]   p_b2w2;
    logic signed [PW-1:0]   p_b0w;
    logic signed [SUMW-1:0] w_sum;
    logic signed [SUMW-1:0] y_sum;
    logic signed [DW:0]     x_rnd;

    // saturate a section sum to the delay-word width
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SUMW-1:0] v);
        if (&v[SUMW-1:DW-1] || ~|v[SUMW-1:DW-1]) begin
            return v[DW-1:0];
        end else if (v[SUMW-1]) begin
            return {1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // saturate the rounded output to the sample width
    function automatic logic [OW-1:0] sat_ow(input logic signed [OW:0] v);
        if (v[OW] == v[OW-1]) begin
            return v[OW-1:0];
        end else if (v[OW]) begin
            return {1'b1, {(OW-1){1'b0}}};
        end else begin
            return {1'b0, {(OW-1){1'b1}}};
        end
    endfunction

    // configuration registers
    bqc_cfg_regs #(
        .SECTIONS (SECTIONS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    // delay memory
    bqc_state_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // products on the delay words of the section last read
    bqc_mul_round u_mul_a1 (.i_clk(i_clk), .i_coef(r_coef.a1), .i_data(rd_data.w1),
                            .o_prod(p_a1w1));
    bqc_mul_round u_mul_a2 (.i_clk(i_clk), .i_coef(r_coef.a2), .i_data(rd_data.w2),
                            .o_prod(p_a2w2));
    bqc_mul_round u_mul_b1 (.i_clk(i_clk), .i_coef(r_coef.b1), .i_data(rd_data.w1),
                            .o_prod(p_b1w1));
    bqc_mul_round u_mul_b2 (.i_clk(i_clk), .i_coef(r_coef.b2), .i_data(rd_data.w2),
                            .o_prod(p_b2w2));
    // product on the new delay word
    bqc_mul_round u_mul_b0 (.i_clk(i_clk), .i_coef(r_coef.b0), .i_data(r_w),
                            .o_prod(p_b0w));

    // memory access: read of section k+1 overlaps write-back of section k,
    // so the same entry is never read and written in one cycle
    assign last_sec = (r_sec == SW'(SECTIONS - 1));
    assign rd_sec   = (r_state == S_P0 || last_sec) ? '0 : r_sec + 1'b1;
    assign rd_en    = (r_state == S_P0) || (r_state == S_B1 && !last_sec);
    assign rd_addr  = r_base + AW'(rd_sec);
    assign wr_en    = (r_state == S_CLEAR) || (r_state == S_B1);

    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_addr = r_clr;
            wr_data = '0;
        end else begin
            wr_addr    = r_base + AW'(r_sec);
            wr_data.w2 = rd_data.w1;
            wr_data.w1 = r_w;
        end
    end

    // section arithmetic
    assign w_sum = r_x - p_a1w1 - p_a2w2;
    assign y_sum = p_b0w + p_b1w1 + p_b2w2;
    assign x_rnd = r_x + (DW + 1)'(signed'(1 << (FRAC - 1)));

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sec    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // result taken; the done state reloads it in the same cycle
            if (r_ovalid && i_m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            if (rd_en) begin
                r_coef <= coefs[rd_sec];
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_chan  <= i_s_axis_tuser;
                        r_base  <= AW'(i_s_axis_tuser * SECTIONS);
                        r_x     <= {i_s_axis_tdata, {FRAC{1'b0}}};
                        r_sec   <= '0;
                        r_oor   <= (32'(i_s_axis_tuser) >= CHANNELS);
                        r_state <= (32'(i_s_axis_tuser) >= CHANNELS) ? S_DONE : S_P0;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_WS;
                S_WS: begin
                    r_w     <= sat_dw(w_sum);
                    r_state <= S_B1;
                end
                S_B1: r_state <= S_B2;
                S_B2: r_state <= S_YS;
                S_YS: begin
                    r_x <= sat_dw(y_sum);
                    if (last_sec) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sec   <= r_sec + 1'b1;
                        r_state <= S_WS;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ochan  <= r_chan;
                        r_odata  <= r_oor ? '0 : sat_ow(x_rnd[DW:FRAC]);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ochan;

endmodule

@@ design/bqc_mul_round.sv @@
// ============================================================================
// bqc_mul_round - two-stage coefficient by delay-word multiply with rounding
// The 40-bit operand is split into a signed high part and an unsigned 16-bit
// low part; the result is the product rounded to 16 fraction bits.
// ============================================================================
module bqc_mul_round (
    input  logic                        i_clk,
    input  logic signed [bqc_pkg::CW-1:0] i_coef,
    input  logic signed [bqc_pkg::DW-1:0] i_data,
    output logic signed [bqc_pkg::PW-1:0] o_prod
);
    import bqc_pkg::*;

    localparam int LW = CW + FRAC + 1;   // low partial product width
    localparam int RW = LW + 1;          // low partial plus rounding constant

    logic signed [DW-FRAC-1:0] hi;
    logic signed [FRAC:0]      lo;
    logic signed [PW-1:0]      r_ph;
    logic signed [LW-1:0]      r_pl;
    logic signed [RW-1:0]      pl_rnd;
    logic signed [RW-FRAC-1:0] pl_carry;
    logic signed [PW-1:0]      r_prod;

    assign hi = i_data[DW-1:FRAC];
    assign lo = {1'b0, i_data[FRAC-1:0]};

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        r_ph <= i_coef * hi;
        r_pl <= i_coef * lo;
    end

    // stage 2: round the low part and merge; the high part has no fraction bits
    assign pl_rnd   = r_pl + RW'(signed'(1 << (FRAC - 1)));
    assign pl_carry = pl_rnd[RW-1:FRAC];

    always_ff @(posedge i_clk) begin
        r_prod <= r_ph + pl_carry;
    end

    assign o_prod = r_prod;

endmodule

@@ design/bqc_state_ram.sv @@
// ============================================================================
// bqc_state_ram - delay-word memory
// One write port and one read port, read data registered and held between
// reads. No reset; the core clears it with a sweep.
// ============================================================================
module bqc_state_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  bqc_pkg::t_delay_pair i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output bqc_pkg::t_delay_pair o_rd_data
);
    import bqc_pkg::*;

    t_delay_pair r_mem [DEPTH];
    t_delay_pair r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bqc_cfg_regs.sv @@
// ============================================================================
// bqc_cfg_regs - coefficient registers behind the APB port
// Numerator and feedback register per section, unpacked into coefficient
// bundles. Sections past the programmable ones pass the signal through.
// ============================================================================
module bqc_cfg_regs #(
    parameter int SECTIONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bqc_pkg::APB_AW-1:0]    paddr,
    input  logic [bqc_pkg::APB_DW-1:0]    pwdata,
    output logic [bqc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output bqc_pkg::t_coef_set            o_coefs [SECTIONS]
);
    import bqc_pkg::*;

    localparam int RSEC = (SECTIONS < REG_SECTIONS) ? SECTIONS : REG_SECTIONS;

    logic [NW-1:0] r_numer [RSEC];
    logic [FW-1:0] r_fback [RSEC];

    logic [APB_AW-REG_IDX_LSB-1:0] reg_idx;
    logic [APB_AW-REG_IDX_LSB-2:0] reg_sec;
    logic                          reg_kind;
    logic                          wr_hit;

    assign reg_idx  = paddr[APB_AW-1:REG_IDX_LSB];
    assign reg_sec  = reg_idx[APB_AW-REG_IDX_LSB-1:1];
    assign reg_kind = reg_idx[0];
    assign wr_hit   = psel && penable && pwrite;
    assign pready   = 1'b1;

    // register writes; sections not present ignore the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RSEC; s++) begin
                r_numer[s] <= NUMER_RESET;
                r_fback[s] <= FBACK_RESET;
            end
        end else if (wr_hit) begin
            for (int s = 0; s < RSEC; s++) begin
                if (32'(reg_sec) == s) begin
                    if (reg_kind == REG_KIND_FBACK) begin
                        r_fback[s] <= pwdata[FW-1:0];
                    end else begin
                        r_numer[s] <= pwdata[NW-1:0];
                    end
                end
            end
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        for (int s = 0; s < RSEC; s++) begin
            if (32'(reg_sec) == s) begin
                if (reg_kind == REG_KIND_FBACK) begin
                    prdata = APB_DW'(r_fback[s]);
                end else begin
                    prdata = APB_DW'(r_numer[s]);
                end
            end
        end
    end

    // coefficient bundles
    for (genvar s = 0; s < SECTIONS; s++) begin : g_coef
        if (s < RSEC) begin : g_prog
            assign o_coefs[s].b0 = r_numer[s][CW-1:0];
            assign o_coefs[s].b1 = r_numer[s][2*CW-1:CW];
            assign o_coefs[s].b2 = r_numer[s][3*CW-1:2*CW];
            assign o_coefs[s].a1 = r_fback[s][CW-1:0];
            assign o_coefs[s].a2 = r_fback[s][2*CW-1:CW];
        end else begin : g_fixed
            assign o_coefs[s].b0 = NUMER_RESET[CW-1:0];
            assign o_coefs[s].b1 = NUMER_RESET[2*CW-1:CW];
            assign o_coefs[s].b2 = NUMER_RESET[3*CW-1:2*CW];
            assign o_coefs[s].a1 = FBACK_RESET[CW-1:0];
            assign o_coefs[s].a2 = FBACK_RESET[2*CW-1:CW];
        end
    end

endmodule

@@ design/bqc_checker.sv @@
// ============================================================================
// bqc_checker - port-level checks of the biquad cascade core
// Watches the stream ports only; attached to the core by the bind below.
// ============================================================================
module bqc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic [bqc_pkg::CHAN_W-1:0] i_s_axis_tuser,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [bqc_pkg::OW-1:0]     o_m_axis_tdata,
    input logic [bqc_pkg::CHAN_W-1:0] o_m_axis_tuser
);
    import bqc_pkg::*;

    logic [CHAN_W-1:0] r_last_chan;

    // channel of the item most recently taken
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_last_chan <= i_s_axis_tuser;
        end
    end

    // reset starts the clearing sweep, which takes no item
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready right after reset");

    // one item at a time: ready drops once an item is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready held after an item was taken");

    // a result that raises valid carries the channel of the item that caused it
    a_chan_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_m_axis_tuser == r_last_chan)
        else $error("result channel differs from the item taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind multichannel_biquad_cascade_core bqc_checker u_bqc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ tb/sv/biquad_cascade_checker.sv @@
// ============================================================================
// biquad_cascade_checker - result predictor and scoreboard of the biquad core
// Snoops register writes and accepted input items, filters each item through
// its own copy of the coefficients and per-channel delay words, and compares
// every accepted result field by field with the oldest predicted one.
// ============================================================================
module biquad_cascade_checker #(
    parameter int CHANNELS = 8,
    parameter int SECTIONS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items as seen at the core
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [bqc_pkg::OW-1:0]          i_in_data,   // [23:0] sample_in
    input  logic [bqc_pkg::CHAN_W-1:0]      i_in_user,   // [2:0] chan
    // result items as seen at the core
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [bqc_pkg::OW-1:0]          i_out_data,  // [23:0] sample_out
    input  logic [bqc_pkg::CHAN_W-1:0]      i_out_user,  // [2:0] chan_out
    // register bus
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [bqc_pkg::APB_AW-1:0]      i_paddr,
    input  logic [bqc_pkg::APB_DW-1:0]      i_pwdata,
    input  logic                            i_pready,
    // status to the test top
    output int                              o_fail_count,
    output int                              o_pending
);
    import bqc_pkg::*;

    typedef struct {
        logic [CHAN_W-1:0] chan;
        logic [OW-1:0]     sample;
    } t_filtered;

    t_filtered         filtered_q[$];
    logic [NW-1:0]     numer_copy [SECTIONS];
    logic [FW-1:0]     fback_copy [SECTIONS];
    longint            w1_mem [CHANNELS*SECTIONS];
    longint            w2_mem [CHANNELS*SECTIONS];
    int                error_cnt;

    // product back to 16 fraction bits, ties toward plus infinity
    function automatic longint round_frac(input longint p);
        return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // runs one sample through all sections of a channel and updates its delays
    function automatic logic [OW-1:0] filter_sample(input int ch, input logic signed [OW-1:0] smp);
        logic signed [CW-1:0] b0, b1, b2, a1, a2;
        longint               x, w, y, d1, d2;
        int                   idx, k;
        if (ch >= CHANNELS) return '0;
        x = longint'(smp) <<< FRAC;
        for (k = 0; k < SECTIONS; k++) begin
            idx          = ch * SECTIONS + k;
            {b2, b1, b0} = numer_copy[k];
            {a2, a1}     = fback_copy[k];
            d1           = w1_mem[idx];
            d2           = w2_mem[idx];
            w = saturate(x - round_frac(a1 * d1) - round_frac(a2 * d2), DW);
            y = saturate(round_frac(b0 * w) + round_frac(b1 * d1) + round_frac(b2 * d2), DW);
            w2_mem[idx] = d1;
            w1_mem[idx] = w;
            x           = y;
        end
        return OW'(saturate(round_frac(x), OW));
    endfunction

    task automatic note_error(input string why, input t_filtered want, input t_filtered got);
        error_cnt++;
        if (error_cnt <= 10)
            $display("%0t: %s: chan exp %0d got %0d, sample exp %0d got %0d", $realtime, why,
                     want.chan, got.chan, $signed(want.sample), $signed(got.sample));
    endtask

    // monitor: register writes, input items, result items
    always @(posedge i_clk) begin : monitor
        t_filtered want, got;
        int        sec;
        if (!i_rst_n) begin
            for (sec = 0; sec < SECTIONS; sec++) begin
                numer_copy[sec] = NUMER_RESET;
                fback_copy[sec] = FBACK_RESET;
            end
            for (sec = 0; sec < CHANNELS * SECTIONS; sec++) begin
                w1_mem[sec] = 0;
                w2_mem[sec] = 0;
            end
            filtered_q.delete();
            error_cnt = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                sec = int'(i_paddr >> (REG_IDX_LSB + 1));
                if (sec < SECTIONS && sec < REG_SECTIONS) begin
                    if (i_paddr[REG_IDX_LSB] == REG_KIND_FBACK)
                        fback_copy[sec] = i_pwdata[FW-1:0];
                    else
                        numer_copy[sec] = i_pwdata[NW-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.chan   = i_in_user;
                want.sample = filter_sample(int'(i_in_user), $signed(i_in_data));
                filtered_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.chan   = i_out_user;
                got.sample = i_out_data;
                if (filtered_q.size() == 0) begin
                    want.chan   = 'x;
                    want.sample = 'x;
                    note_error("result with none expected", want, got);
                end else begin
                    want = filtered_q.pop_front();
                    if (want.chan !== got.chan || want.sample !== got.sample)
                        note_error("result mismatch", want, got);
                end
            end
        end
        o_fail_count <= error_cnt;
        o_pending    <= filtered_q.size();
    end

endmodule

@@ tb/sv/multichannel_biquad_cascade_core_test.sv @@
// ============================================================================
// multichannel_biquad_cascade_core_test - stimulus and verdict for the core
// Programs coefficient sets over the register bus, streams channel-tagged
// samples with random gaps and back-pressure, and leaves prediction and
// comparison to the checker instantiated beside the core.
// ============================================================================
module multichannel_biquad_cascade_core_test;
    import bqc_pkg::*;

    localparam int CHANNELS = 8;
    localparam int SECTIONS = 4;
    localparam int SET_ITEMS = 120;

    localparam logic [OW-1:0] EDGE_SAMPLES [8] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
        24'h000001, 24'h555555, 24'hAAAAAA, 24'h123456
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [OW-1:0]       s_tdata;
    logic [CHAN_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OW-1:0]       m_tdata;
    logic [CHAN_W-1:0]   m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  src_idle;
    int                  snk_idle;

    multichannel_biquad_cascade_core #(
        .CHANNELS (CHANNELS),
        .SECTIONS (SECTIONS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    biquad_cascade_checker #(
        .CHANNELS (CHANNELS),
        .SECTIONS (SECTIONS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result back-pressure
    always @(negedge i_clk) begin
        m_tready = ($urandom_range(99) >= snk_idle);
    end

    // run limit
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // one register write: setup then access; called at a falling edge
    task automatic write_reg(input int sec, input logic kind, input logic [APB_DW-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'((2 * sec + int'(kind)) << REG_IDX_LSB);
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_section(input int sec, input int b0, input int b1, input int b2,
                                input int a1, input int a2);
        write_reg(sec, REG_KIND_NUMER, APB_DW'({CW'(b2), CW'(b1), CW'(b0)}));
        write_reg(sec, REG_KIND_FBACK, APB_DW'({CW'(a2), CW'(a1)}));
    endtask

    // hands one item over; valid stays high into the next item unless a gap is drawn
    task automatic send_sample(input int ch, input logic [OW-1:0] smp);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tuser  = CHAN_W'(ch);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // core idle: every result back, then a pause longer than one item's latency
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [OW-1:0] pick_sample();
        case ($urandom_range(9))
            0:          return EDGE_SAMPLES[$urandom_range(3)];
            1, 2, 3, 4: return OW'($urandom);
            default:    return OW'(int'($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // mostly stable sections, some arbitrary register contents, some plain gains
    task automatic program_random_set();
        int sec, a1, a2, lim;
        for (sec = 0; sec < SECTIONS; sec++) begin
            case ($urandom_range(9))
                7, 8: begin
                    write_reg(sec, REG_KIND_NUMER, {$urandom, $urandom});
                    write_reg(sec, REG_KIND_FBACK, {$urandom, $urandom});
                end
                9: load_section(sec, int'($urandom_range(2 * 131072)) - 131072, 0, 0, 0, 0);
                default: begin
                    a2  = int'($urandom_range(2 * 58982)) - 58982;
                    lim = ((65536 + a2) * 95) / 100;
                    a1  = int'($urandom_range(2 * lim)) - lim;
                    load_section(sec, int'($urandom_range(98304)) - 49152,
                                 int'($urandom_range(98304)) - 49152,
                                 int'($urandom_range(98304)) - 49152, a1, a2);
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int i, sec, mode, set_no;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        src_idle = 21;
        snk_idle = 71;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients pass samples through: the edge samples, one per channel
        for (i = 0; i < CHANNELS; i++)
            send_sample(i, EDGE_SAMPLES[i]);

        // all-ones registers, bits above the register width set too
        wait_idle();
        for (sec = 0; sec < SECTIONS; sec++) begin
            write_reg(sec, REG_KIND_NUMER, '1);
            write_reg(sec, REG_KIND_FBACK, '1);
        end
        for (i = 0; i < 4; i++)
            send_sample(i, EDGE_SAMPLES[i]);

        // largest gains with most negative feedback: runaway into both rails
        wait_idle();
        for (sec = 0; sec < SECTIONS; sec++)
            load_section(sec, 524287, 524287, 524287, -524288, -524288);
        for (i = 0; i < 8; i++)
            send_sample((i % 2) * 7, EDGE_SAMPLES[i % 2]);

        // most negative b0, largest positive feedback
        wait_idle();
        for (sec = 0; sec < SECTIONS; sec++)
            load_section(sec, -524288, 0, 0, 524287, 524287);
        for (i = 0; i < 4; i++)
            send_sample(i + 1, EDGE_SAMPLES[i + 4]);

        // random part, three pacing modes
        for (mode = 0; mode < 3; mode++) begin
            wait_idle();
            src_idle = (mode == 0) ? 21 : (mode == 1) ? 71 : 0;
            snk_idle = (mode == 0) ? 71 : (mode == 1) ? 21 : 0;
            for (set_no = 0; set_no < 4; set_no++) begin
                wait_idle();
                program_random_set();
                repeat (SET_ITEMS)
                    send_sample($urandom_range(CHANNELS - 1), pick_sample());
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
